FILE: hdl/rte_pkg.sv
// shared types and codes for the route table engine
`default_nettype none

package rte_pkg;

    // operation codes
    localparam logic [1:0] FN_UPDATE     = 2'd0;
    localparam logic [1:0] FN_LOOKUP     = 2'd1;
    localparam logic [1:0] FN_INVALIDATE = 2'd2;
    localparam logic [1:0] FN_ERASE      = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_KEPT     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // removal counter saturates here
    localparam logic [4:0] COUNT_MAX = 5'd31;

    // one stored route
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] next_hop;
        logic [7:0]  hops;
    } t_entry;

    // table access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_tbl_cmd;

endpackage

`default_nettype wire

FILE: hdl/rte_if.sv
// request and result channel interfaces of the route table engine
`default_nettype none

interface rte_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] node_id;
    logic [31:0] via_hop;
    logic [7:0]  hop_count;

    modport source (output valid, func, node_id, via_hop, hop_count, input ready);
    modport sink (input valid, func, node_id, via_hop, hop_count, output ready);
endinterface

interface rte_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] route_next_hop;
    logic [7:0]  route_hops;
    logic [1:0]  status;
    logic [4:0]  removed_count;

    modport source (output valid, found, route_next_hop, route_hops, status,
                    removed_count, input ready);
    modport sink (input valid, found, route_next_hop, route_hops, status,
                  removed_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/rte_route_mem.sv
// route storage: entry memory with registered read and per-entry valid flops
`default_nettype none

module rte_route_mem #(
    parameter int ENTRIES = 16,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire rte_pkg::t_tbl_cmd i_cmd,
    input  wire  [AW-1:0]          i_rd_idx,
    input  wire  [AW-1:0]          i_wr_idx,
    input  wire rte_pkg::t_entry   i_wr_entry,
    input  wire  [AW-1:0]          i_clr_idx,
    output rte_pkg::t_entry        o_rd_entry,
    output logic                   o_rd_valid
);
    import rte_pkg::*;

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_entry             r_rd_entry;
    logic               r_rd_valid;

    // entry memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
    end

    // registered read of entry and its valid flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_entry <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    // valid flags: cleared by reset, set on write, cleared on removal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
            if (i_cmd.wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire

FILE: hdl/route_table_engine.sv
// route table engine top level: request sequencer, entry scan and result register
//
// Usage: requests arrive on i_in (func, node_id, via_hop, hop_count) and one
// result per request leaves on o_out (found, route_next_hop, route_hops,
// status, removed_count). Both channels use valid/ready; an item moves at a
// rising edge with valid and ready high.
// Each request scans every table entry through the single read port of the
// route memory, one entry per cycle, compares it, then commits any update or
// erase in a final commit state. The result register is loaded when the commit
// completes; the next request is accepted only once the sequencer is back in
// idle, so no request is taken while another is still in progress.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver still holds off when the next result is ready, the
// sequencer waits in its commit cycle and no further request is taken.
// Reset (i_rst_n low, synchronous) clears every valid flag at once, so the
// table comes up empty with no clearing pass, and drops any pending result.
`default_nettype none

module route_table_engine #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rte_in_if.sink     i_in,
    rte_out_if.source  o_out
);
    import rte_pkg::*;

    localparam int AW = $clog2(ROUTE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ROUTE_ENTRIES - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state, n_state;

    // captured request
    logic [1:0]    r_func;
    logic [31:0]   r_node;
    logic [31:0]   r_via;
    logic [7:0]    r_hops;

    // scan control
    logic [AW-1:0] r_rd_idx;
    logic          r_issue_done;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;

    // scan findings
    logic          r_key_hit;
    logic [AW-1:0] r_key_idx;
    logic [31:0]   r_key_next;
    logic [7:0]    r_key_hops;
    logic          r_free_hit;
    logic [AW-1:0] r_free_idx;
    logic [4:0]    r_removed;

    // result register
    logic          r_out_vld;
    logic          r_out_found;
    logic [31:0]   r_out_next;
    logic [7:0]    r_out_hops;
    logic [1:0]    r_out_status;
    logic [4:0]    r_out_removed;

    // memory port signals
    t_tbl_cmd      tbl_cmd;
    logic [AW-1:0] wr_idx;
    t_entry        wr_entry;
    logic [AW-1:0] clr_idx;
    t_entry        rd_entry;
    logic          rd_valid;

    // commit cycle results
    logic          fin_go;
    logic          n_found;
    logic [31:0]   n_next;
    logic [7:0]    n_hops;
    logic [1:0]    n_status;
    logic [4:0]    n_removed;

    // compare stage
    logic          key_match;
    logic          hop_match;
    logic          inval_hit;
    logic          free_seen;

    rte_route_mem #(
        .ENTRIES (ROUTE_ENTRIES),
        .AW      (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_rd_idx   (r_rd_idx),
        .i_wr_idx   (wr_idx),
        .i_wr_entry (wr_entry),
        .i_clr_idx  (clr_idx),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid)
    );

    // no item is taken while reset is held
    assign i_in.ready = i_rst_n && (r_state == S_IDLE);

    // compare the entry read last cycle against the request key
    assign key_match = r_cmp_vld && rd_valid && (rd_entry.dest == r_node);
    assign hop_match = r_cmp_vld && rd_valid && (rd_entry.next_hop == r_node);
    assign inval_hit = (r_func == FN_INVALIDATE) && (key_match || hop_match);
    assign free_seen = r_cmp_vld && !rd_valid && !r_free_hit;

    // commit may proceed once the result register is free
    assign fin_go = (r_state == S_FIN) && (!r_out_vld || o_out.ready);

    // commit decision and memory commands (scan reads, writes and clears)
    always_comb begin
        n_found   = r_key_hit;
        n_next    = '0;
        n_hops    = '0;
        n_status  = ST_DONE;
        n_removed = '0;
        wr_idx    = r_key_idx;
        wr_entry  = '{dest: r_node, next_hop: r_via, hops: r_hops};
        tbl_cmd   = '{rd_en: 1'b0, wr_en: 1'b0, clr_en: 1'b0};
        clr_idx   = r_cmp_idx;

        if ((r_state == S_SCAN) && !r_issue_done) begin
            tbl_cmd.rd_en = 1'b1;
        end
        if (inval_hit) begin
            tbl_cmd.clr_en = 1'b1;
        end

        case (r_func)
            FN_UPDATE: begin
                if (r_key_hit) begin
                    if (r_hops < r_key_hops) begin
                        n_status      = ST_REPLACED;
                        n_next        = r_via;
                        n_hops        = r_hops;
                        tbl_cmd.wr_en = fin_go;
                    end else begin
                        n_status = ST_KEPT;
                        n_next   = r_key_next;
                        n_hops   = r_key_hops;
                    end
                end else if (r_free_hit) begin
                    n_status      = ST_DONE;
                    wr_idx        = r_free_idx;
                    tbl_cmd.wr_en = fin_go;
                end else begin
                    n_status = ST_FULL;
                end
            end
            FN_LOOKUP: begin
                if (r_key_hit) begin
                    n_next = r_key_next;
                    n_hops = r_key_hops;
                end
            end
            FN_INVALIDATE: begin
                n_removed = r_removed;
            end
            FN_ERASE: begin
                if (r_key_hit) begin
                    n_removed = 5'd1;
                    clr_idx   = r_key_idx;
                    if (fin_go) begin
                        tbl_cmd.clr_en = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_key_hit    <= 1'b0;
            r_free_hit   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_in.valid && i_in.ready) begin
                r_issue_done <= 1'b0;
                r_cmp_vld    <= 1'b0;
                r_key_hit    <= 1'b0;
                r_free_hit   <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_cmp_vld <= !r_issue_done;
                if (!r_issue_done && (r_rd_idx == LAST_IDX)) begin
                    r_issue_done <= 1'b1;
                end
                if (key_match) begin
                    r_key_hit <= 1'b1;
                end
                if (free_seen) begin
                    r_free_hit <= 1'b1;
                end
            end else begin
                r_cmp_vld <= 1'b0;
            end

            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request capture, scan address and findings
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func    <= i_in.func;
            r_node    <= i_in.node_id;
            r_via     <= i_in.via_hop;
            r_hops    <= i_in.hop_count;
            r_rd_idx  <= '0;
            r_removed <= '0;
        end else if (r_state == S_SCAN) begin
            if (!r_issue_done) begin
                r_cmp_idx <= r_rd_idx;
                if (r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= r_rd_idx + AW'(1);
                end
            end
            if (key_match) begin
                r_key_idx  <= r_cmp_idx;
                r_key_next <= rd_entry.next_hop;
                r_key_hops <= rd_entry.hops;
            end
            if (free_seen) begin
                r_free_idx <= r_cmp_idx;
            end
            if (inval_hit && (r_removed != COUNT_MAX)) begin
                r_removed <= r_removed + 5'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_found   <= n_found;
            r_out_next    <= n_next;
            r_out_hops    <= n_hops;
            r_out_status  <= n_status;
            r_out_removed <= n_removed;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.found          = r_out_found;
    assign o_out.route_next_hop = r_out_next;
    assign o_out.route_hops     = r_out_hops;
    assign o_out.status         = r_out_status;
    assign o_out.removed_count  = r_out_removed;

    // an accepted item always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SCAN))
        else $error("accepted item did not start a scan");

    // destinations are unique, so a scan never matches the key twice
    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_key_hit) |-> !key_match)
        else $error("key matched more than one entry");

    // a dropped insert reports no route
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_FULL) |->
        (!o_out.found && o_out.route_next_hop == 32'd0 && o_out.route_hops == 8'd0))
        else $error("full status with route data");

    // removals never exceed the table size
    a_removed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (int'(o_out.removed_count) <= ROUTE_ENTRIES))
        else $error("removed count above table size");

    // a commit only happens when the result register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !fin_go)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: tb/tb_route_table_engine.sv
// testbench for the route table engine: directed table, then random traffic checked by a predictor
module tb_route_table_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import rte_pkg::*;

    localparam int ENTRIES = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASES = 4;
    localparam int POOL_MAX = 64;
    localparam int unsigned POOL_SIZES [PHASES] = '{8, 18, 30, 13};

    // receiver stall modes
    localparam int unsigned RX_OPEN   = 0;
    localparam int unsigned RX_RANDOM = 1;
    localparam int unsigned RX_HOLD   = 2;
    localparam int unsigned RX_SPARSE = 3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] node_id;
        logic [31:0] via_hop;
        logic [7:0]  hop_count;
    } t_route_req;

    typedef struct packed {
        logic        found;
        logic [31:0] next_hop;
        logic [7:0]  hops;
        logic [1:0]  status;
        logic [4:0]  removed;
    } t_route_res;

    // one directed row: request, repeat count (node id steps by one), optional typed answer
    typedef struct packed {
        t_route_req req;
        logic [7:0] reps;
        logic       has_exp;
        t_route_res res;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // lookup and erase on an empty table
        '{'{FN_LOOKUP, 32'h0, 32'h0, 8'd0}, 8'd1, 1'b1, '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd0}},
        '{'{FN_ERASE, 32'hFFFF_FFFF, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd0}},
        // new routes at the key and hop extremes
        '{'{FN_UPDATE, 32'h0, 32'hFFFF_FFFF, 8'd255}, 8'd1, 1'b1,
          '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd0}},
        '{'{FN_UPDATE, 32'hFFFF_FFFF, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd0}},
        '{'{FN_LOOKUP, 32'h0, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 8'd255, ST_DONE, 5'd0}},
        // equal hop count keeps, shorter replaces, longer keeps
        '{'{FN_UPDATE, 32'h0, 32'h1234, 8'd255}, 8'd1, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 8'd255, ST_KEPT, 5'd0}},
        '{'{FN_UPDATE, 32'h0, 32'h1234, 8'd254}, 8'd1, 1'b1,
          '{1'b1, 32'h1234, 8'd254, ST_REPLACED, 5'd0}},
        '{'{FN_UPDATE, 32'hFFFF_FFFF, 32'h7, 8'd200}, 8'd1, 1'b1,
          '{1'b1, 32'h0, 8'd0, ST_KEPT, 5'd0}},
        // erase of a present key frees the second slot
        '{'{FN_ERASE, 32'hFFFF_FFFF, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b1, 32'h0, 8'd0, ST_DONE, 5'd1}},
        // fill the table, then a new key is dropped while existing keys still update
        '{'{FN_UPDATE, 32'd100, 32'h1234, 8'd3}, 8'd15, 1'b1,
          '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd0}},
        '{'{FN_UPDATE, 32'd200, 32'h9, 8'd1}, 8'd1, 1'b1, '{1'b0, 32'h0, 8'd0, ST_FULL, 5'd0}},
        '{'{FN_UPDATE, 32'd100, 32'h9, 8'd1}, 8'd1, 1'b1,
          '{1'b1, 32'h9, 8'd1, ST_REPLACED, 5'd0}},
        // invalidate by next hop only, then by key
        '{'{FN_INVALIDATE, 32'h1234, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd15}},
        '{'{FN_INVALIDATE, 32'd100, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b1, 32'h0, 8'd0, ST_DONE, 5'd1}},
        // absent broken node still removes routes through it
        '{'{FN_UPDATE, 32'd300, 32'd400, 8'd2}, 8'd1, 1'b0, '0},
        '{'{FN_UPDATE, 32'd301, 32'd400, 8'd5}, 8'd1, 1'b0, '0},
        '{'{FN_INVALIDATE, 32'd400, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd2}},
        // route through itself is removed once
        '{'{FN_UPDATE, 32'd500, 32'd500, 8'd1}, 8'd1, 1'b0, '0},
        '{'{FN_INVALIDATE, 32'd500, 32'h0, 8'd0}, 8'd1, 1'b1,
          '{1'b1, 32'h0, 8'd0, ST_DONE, 5'd1}},
        '{'{FN_LOOKUP, 32'd500, 32'h0, 8'd0}, 8'd1, 1'b1, '{1'b0, 32'h0, 8'd0, ST_DONE, 5'd0}},
        // alternating bit patterns
        '{'{FN_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55}, 8'd1, 1'b0, '0},
        '{'{FN_LOOKUP, 32'h5555_5555, 32'h0, 8'd0}, 8'd1, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    rte_in_if  req_if ();
    rte_out_if res_if ();

    route_table_engine #(
        .ROUTE_ENTRIES(ENTRIES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (req_if),
        .o_out  (res_if)
    );

    // predicted table contents
    bit          tbl_valid [ENTRIES];
    logic [31:0] tbl_dest [ENTRIES];
    logic [31:0] tbl_next [ENTRIES];
    logic [7:0]  tbl_hops [ENTRIES];

    t_route_res  pending_routes [$];
    int          fail_count;
    int unsigned burst_left;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // apply one request to the predicted table and return its result
    function automatic t_route_res apply_route_op(input t_route_req req);
        t_route_res res;
        int hit;
        int slot;
        int i;
        res = '0;
        res.status = ST_DONE;
        hit = -1;
        slot = -1;
        for (i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_dest[i] == req.node_id) hit = i;
            if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        res.found = (hit >= 0);
        case (req.func)
            FN_UPDATE: begin
                if (hit >= 0) begin
                    if (req.hop_count < tbl_hops[hit]) begin
                        tbl_next[hit] = req.via_hop;
                        tbl_hops[hit] = req.hop_count;
                        res.status = ST_REPLACED;
                    end else begin
                        res.status = ST_KEPT;
                    end
                    res.next_hop = tbl_next[hit];
                    res.hops = tbl_hops[hit];
                end else if (slot >= 0) begin
                    // new route takes the lowest free slot
                    tbl_valid[slot] = 1'b1;
                    tbl_dest[slot] = req.node_id;
                    tbl_next[slot] = req.via_hop;
                    tbl_hops[slot] = req.hop_count;
                end else begin
                    res.status = ST_FULL;
                end
            end
            FN_LOOKUP: begin
                if (hit >= 0) begin
                    res.next_hop = tbl_next[hit];
                    res.hops = tbl_hops[hit];
                end
            end
            FN_INVALIDATE: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] &&
                        (tbl_dest[i] == req.node_id || tbl_next[i] == req.node_id)) begin
                        tbl_valid[i] = 1'b0;
                        // saturating count
                        if (res.removed != COUNT_MAX) res.removed = res.removed + 5'd1;
                    end
                end
            end
            default: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    res.removed = 5'd1;
                end
            end
        endcase
        return res;
    endfunction

    // drive one request in bursts with random gaps, record its result on acceptance
    task automatic send_route_req(input t_route_req req, input logic has_exp,
                                  input t_route_res typed_res);
        t_route_res predicted;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.func <= req.func;
        req_if.node_id <= req.node_id;
        req_if.via_hop <= req.via_hop;
        req_if.hop_count <= req.hop_count;
        do @(posedge clk); while (!req_if.ready);
        predicted = apply_route_op(req);
        if (has_exp) predicted = typed_res;
        pending_routes.insert(pending_routes.size(), predicted);
    endtask

    // hold the sender until every outstanding result is back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_routes.size() != 0);
    endtask

    // receiver stall pattern
    initial begin
        int unsigned mode;
        int unsigned run_left;
        mode = RX_OPEN;
        run_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (run_left == 0) begin
                mode = $urandom_range(RX_OPEN, RX_SPARSE);
                run_left = (mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(5, 60);
            end
            run_left--;
            case (mode)
                RX_OPEN:   res_if.ready <= 1'b1;
                RX_RANDOM: res_if.ready <= ($urandom_range(0, 1) != 0);
                RX_HOLD:   res_if.ready <= 1'b0;
                default:   res_if.ready <= (run_left % 3 == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk) begin : check_results
        t_route_res want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_routes.size() == 0) begin
                $error("result item with no request outstanding");
                fail_count++;
            end else begin
                want = pending_routes.pop_front();
                if (res_if.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, res_if.found);
                    fail_count++;
                end
                if (res_if.route_next_hop !== want.next_hop) begin
                    $error("route_next_hop: expected %h, got %h",
                           want.next_hop, res_if.route_next_hop);
                    fail_count++;
                end
                if (res_if.route_hops !== want.hops) begin
                    $error("route_hops: expected %0d, got %0d", want.hops, res_if.route_hops);
                    fail_count++;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    fail_count++;
                end
                if (res_if.removed_count !== want.removed) begin
                    $error("removed_count: expected %0d, got %0d",
                           want.removed, res_if.removed_count);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_route_req  req;
        logic [31:0] key_pool [POOL_MAX];
        int unsigned pool_size;
        int unsigned pick;
        int unsigned settle;
        int r;
        int k;
        int p;
        int n;

        fail_count = 0;
        burst_left = 0;
        for (r = 0; r < ENTRIES; r++) begin
            tbl_valid[r] = 1'b0;
            tbl_dest[r] = '0;
            tbl_next[r] = '0;
            tbl_hops[r] = '0;
        end
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.func <= FN_UPDATE;
        req_if.node_id <= '0;
        req_if.via_hop <= '0;
        req_if.hop_count <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            for (k = 0; k < int'(DIRECTED[r].reps); k++) begin
                req = DIRECTED[r].req;
                req.node_id = req.node_id + 32'(k);
                send_route_req(req, DIRECTED[r].has_exp, DIRECTED[r].res);
            end
        end
        drain_results();

        // random phases, each over its own key pool so the table fills to different levels
        for (p = 0; p < PHASES; p++) begin
            pool_size = POOL_SIZES[p];
            for (n = 0; n < int'(pool_size); n++) begin
                pick = $urandom_range(0, 7);
                if (pick == 0) key_pool[n] = 32'h0;
                else if (pick == 1) key_pool[n] = 32'hFFFF_FFFF;
                else if (pick == 2) key_pool[n] = $urandom_range(1, 40);
                else key_pool[n] = $urandom;
            end
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) req.func = FN_UPDATE;
                else if (pick < 70) req.func = FN_LOOKUP;
                else if (pick < 82) req.func = FN_INVALIDATE;
                else req.func = FN_ERASE;
                // mostly pooled keys and hops, some noise outside the pool
                req.node_id = ($urandom_range(0, 9) == 0) ? $urandom
                                                          : key_pool[$urandom_range(0, pool_size - 1)];
                req.via_hop = ($urandom_range(0, 7) == 0) ? $urandom
                                                          : key_pool[$urandom_range(0, pool_size - 1)];
                pick = $urandom_range(0, 19);
                if (pick == 0) req.hop_count = 8'd0;
                else if (pick == 1) req.hop_count = 8'd255;
                else req.hop_count = 8'($urandom_range(0, 255));
                send_route_req(req, 1'b0, '0);
            end
            drain_results();
        end

        // wait out the last results
        req_if.valid <= 1'b0;
        settle = 0;
        while (pending_routes.size() != 0 && settle < 4000) begin
            @(posedge clk);
            settle++;
        end
        repeat (40) @(posedge clk);
        if (pending_routes.size() != 0) begin
            $error("%0d result items never arrived", pending_routes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/rte_pkg.sv
hdl/rte_if.sv
hdl/rte_route_mem.sv
hdl/route_table_engine.sv
tb/tb_route_table_engine.sv
